/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the positional list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold on every clock edge out of reset.
`define PLC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen on a clock edge out of reset.
`define PLC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PLC_ASSERT(lbl, prop, msg)
`define PLC_NEVER(lbl, cond, msg)
`endif
`endif

/* sv/plc_pkg.sv */
// Package of types and constants for the positional list with cursor.
`timescale 1ns / 1ps
`default_nettype none
package plc_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // stream payload widths
    localparam int ACT_W    = 3;
    localparam int POS_W    = 6;
    localparam int STAT_W   = 2;
    localparam int IN_W     = 40;
    localparam int IN_USER_W = ACT_W;
    localparam int OUT_W    = 56;

    typedef enum logic [ACT_W-1:0] {
        ACT_QUERY    = 3'd0,
        ACT_INSERT   = 3'd1,
        ACT_REMOVE   = 3'd2,
        ACT_TO_START = 3'd3,
        ACT_TO_END   = 3'd4,
        ACT_BACK     = 3'd5,
        ACT_FORWARD  = 3'd6,
        ACT_TO_POS   = 3'd7
    } act_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INS_WR,
        ST_FETCH,
        ST_RESP
    } state_t;

endpackage
`default_nettype wire

/* sv/positional_list_with_cursor.sv */
// Top level of the positional list with cursor: sequencer, entry memory and stream ports.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Ordered list of up to 64 signed 32-bit words with a cursor. Each request on the
// input stream carries one action (query, insert, remove, to start, to end, back,
// forward, to position) and yields exactly one response with the length, the cursor,
// the word under the cursor with its valid flag, and a status. The entries live in a
// single-port-write, single-read memory with a registered read, so insert and remove
// move entries one at a time: each entry shifted is read, then written.
// A request that writes no word goes through accept, memory fetch and response; an
// insert that goes ahead first moves the entries from the cursor up by one and writes
// the new word, a remove that goes ahead moves the entries past the cursor down by one,
// refused ones fetch at once; a response that cannot leave waits for the output register.
// The input is not ready while a request is in progress; a finished response waits in
// an output register so the next request may be taken before it is collected. There is
// no clearing pass after reset.
module positional_list_with_cursor (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // s_tdata: item_value[31:0], target_position[37:32], zero pad
    input  wire logic [plc_pkg::IN_W-1:0]      s_tdata,
    // s_tuser: action[2:0]
    input  wire logic [plc_pkg::IN_USER_W-1:0] s_tuser,
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    // m_tdata: list_length[6:0], cursor_position[13:7], cursor_value[45:14],
    //          value_valid[46], status[48:47], zero pad
    output      logic [plc_pkg::OUT_W-1:0]     m_tdata,
    output      logic                         m_tvalid,
    input  wire logic                         m_tready
);
    import plc_pkg::*;

    // entry memory
    logic [DATA_W-1:0] entry_store [CAPACITY];

    state_t            state_reg,   state_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [CNT_W-1:0]  cursor_reg,  cursor_next;
    logic [IDX_W-1:0]  ptr_reg,     ptr_next;
    logic              ins_reg,     ins_next;
    logic [DATA_W-1:0] value_reg,   value_next;
    status_t           status_reg,  status_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg,  m_tdata_next;
    logic [DATA_W-1:0] rd_data_reg;

    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;

    // request fields
    act_t              in_act;
    logic [DATA_W-1:0] in_value;
    logic [POS_W-1:0]  in_pos;
    logic              accept;

    // response fields
    logic              resp_valid;
    logic [DATA_W-1:0] resp_value;

    assign in_act   = act_t'(s_tuser[ACT_W-1:0]);
    assign in_value = s_tdata[DATA_W-1:0];
    assign in_pos   = s_tdata[DATA_W +: POS_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign resp_valid = (cursor_reg < count_reg);
    assign resp_value = resp_valid ? rd_data_reg : '0;

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cursor_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cursor_reg   <= cursor_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        ins_reg     <= ins_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_store[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_store[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        ptr_next      = ptr_reg;
        ins_next      = ins_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        rd_addr       = cursor_reg[IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = ptr_reg;
        wr_data       = rd_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    value_next  = in_value;
                    status_next = STAT_DONE;
                    state_next  = ST_FETCH;
                    case (in_act)
                        ACT_INSERT:
                        begin
                            ins_next = 1'b1;
                            ptr_next = count_reg[IDX_W-1:0];
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (count_reg == cursor_reg)
                            begin
                                state_next = ST_INS_WR;
                            end
                            else
                            begin
                                state_next = ST_SHIFT_RD;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            ins_next = 1'b0;
                            ptr_next = cursor_reg[IDX_W-1:0];
                            if (cursor_reg >= count_reg)
                            begin
                                status_next = STAT_IGNORED;
                            end
                            else if (CNT_W'(cursor_reg + 1'b1) < count_reg)
                            begin
                                state_next = ST_SHIFT_RD;
                            end
                            else
                            begin
                                // last entry goes, nothing to move
                                count_next = CNT_W'(count_reg - 1'b1);
                            end
                        end
                        ACT_TO_START:
                        begin
                            cursor_next = '0;
                        end
                        ACT_TO_END:
                        begin
                            cursor_next = (count_reg != '0) ? CNT_W'(count_reg - 1'b1) : '0;
                        end
                        ACT_BACK:
                        begin
                            if (cursor_reg == '0)
                            begin
                                status_next = STAT_IGNORED;
                            end
                            else
                            begin
                                cursor_next = CNT_W'(cursor_reg - 1'b1);
                            end
                        end
                        ACT_FORWARD:
                        begin
                            if (CNT_W'(cursor_reg + 1'b1) < count_reg)
                            begin
                                cursor_next = CNT_W'(cursor_reg + 1'b1);
                            end
                            else
                            begin
                                status_next = STAT_IGNORED;
                            end
                        end
                        ACT_TO_POS:
                        begin
                            if (CNT_W'(in_pos) < count_reg)
                            begin
                                cursor_next = CNT_W'(in_pos);
                            end
                            else
                            begin
                                status_next = STAT_IGNORED;
                            end
                        end
                        default:
                        begin
                            // query: state stays as it is
                        end
                    endcase
                end
            end

            // read the neighbour that moves into ptr
            ST_SHIFT_RD:
            begin
                rd_addr    = ins_reg ? IDX_W'(ptr_reg - 1'b1) : IDX_W'(ptr_reg + 1'b1);
                state_next = ST_SHIFT_WR;
            end

            // write it at ptr and step on
            ST_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_data = rd_data_reg;
                if (ins_reg)
                begin
                    ptr_next = IDX_W'(ptr_reg - 1'b1);
                    if (CNT_W'(IDX_W'(ptr_reg - 1'b1)) == cursor_reg)
                    begin
                        state_next = ST_INS_WR;
                    end
                    else
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                end
                else
                begin
                    ptr_next = IDX_W'(ptr_reg + 1'b1);
                    if (CNT_W'(CNT_W'(ptr_reg) + CNT_W'(2)) < count_reg)
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        count_next = CNT_W'(count_reg - 1'b1);
                        state_next = ST_FETCH;
                    end
                end
            end

            // new word lands under the cursor
            ST_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = cursor_reg[IDX_W-1:0];
                wr_data    = value_reg;
                count_next = CNT_W'(count_reg + 1'b1);
                state_next = ST_FETCH;
            end

            // read the word under the cursor
            ST_FETCH:
            begin
                state_next = ST_RESP;
            end

            // hand the response over once the output register is free
            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({status_reg, resp_valid, resp_value,
                                            cursor_reg, count_reg});
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks
    `PLC_ASSERT(a_cursor_in_list, cursor_reg <= count_reg, "cursor beyond list length")
    `PLC_ASSERT(a_count_cap, count_reg <= CNT_W'(CAPACITY), "list length beyond capacity")
    `PLC_ASSERT(a_valid_flag, m_tvalid_reg |-> (m_tdata_reg[2*CNT_W+DATA_W] == (m_tdata_reg[2*CNT_W-1:CNT_W] < m_tdata_reg[CNT_W-1:0])), "value_valid disagrees with cursor and length")
    `PLC_ASSERT(a_full_status, (m_tvalid_reg && (m_tdata_reg[2*CNT_W+DATA_W+1 +: STAT_W] == STAT_FULL)) |-> (m_tdata_reg[CNT_W-1:0] == CNT_W'(CAPACITY)), "full status on a list with room")

endmodule
`default_nettype wire

/* verif/tb_positional_list_with_cursor.sv */
// Self-checking testbench for the positional list with cursor.
`timescale 1ns / 1ps
`default_nettype none
module tb_positional_list_with_cursor;
    import plc_pkg::*;

    localparam int RAND_REQUESTS = 1900;
    localparam int PHASE_LEN     = 250;
    localparam int HOLD_PERIOD   = 15000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 150;

    // expected reply to one request
    typedef struct {
        logic [6:0]        length;
        logic [6:0]        cursor;
        logic [DATA_W-1:0] value;
        logic              valid;
        status_t           status;
    } list_reply_t;

    // Shadow list: applies each accepted action and queues the reply it must give
    class list_scoreboard;
        logic [DATA_W-1:0] shadow_entries [CAPACITY];
        int                shadow_len;
        int                shadow_cursor;
        list_reply_t       expected_replies [$];
        int                mismatches;

        function new();
            shadow_len    = 0;
            shadow_cursor = 0;
            mismatches    = 0;
        endfunction

        function void apply_action(act_t act, logic [DATA_W-1:0] value, logic [POS_W-1:0] target);
            status_t     st;
            list_reply_t r;
            st = STAT_DONE;
            case (act)
                ACT_INSERT:
                    if (shadow_len >= CAPACITY)
                        st = STAT_FULL;
                    else if (shadow_cursor > shadow_len)
                        st = STAT_IGNORED;
                    else
                    begin
                        for (int i = shadow_len; i > shadow_cursor; i--)
                            shadow_entries[i] = shadow_entries[i-1];
                        shadow_entries[shadow_cursor] = value;
                        shadow_len++;
                    end
                ACT_REMOVE:
                    if (shadow_cursor >= shadow_len)
                        st = STAT_IGNORED;
                    else
                    begin
                        for (int i = shadow_cursor; i + 1 < shadow_len; i++)
                            shadow_entries[i] = shadow_entries[i+1];
                        shadow_len--;
                    end
                ACT_TO_START:
                    shadow_cursor = 0;
                ACT_TO_END:
                    shadow_cursor = (shadow_len > 0) ? shadow_len - 1 : 0;
                ACT_BACK:
                    if (shadow_cursor == 0 || shadow_cursor > shadow_len)
                        st = STAT_IGNORED;
                    else
                        shadow_cursor--;
                ACT_FORWARD:
                    if (shadow_cursor + 1 < shadow_len)
                        shadow_cursor++;
                    else
                        st = STAT_IGNORED;
                ACT_TO_POS:
                    if (int'(target) < shadow_len)
                        shadow_cursor = int'(target);
                    else
                        st = STAT_IGNORED;
                default: ;
            endcase
            r.length = shadow_len[6:0];
            r.cursor = shadow_cursor[6:0];
            r.valid  = (shadow_cursor < shadow_len);
            r.value  = r.valid ? shadow_entries[shadow_cursor] : '0;
            r.status = st;
            expected_replies.push_back(r);
        endfunction

        function void check_reply(logic [OUT_W-1:0] data);
            list_reply_t exp_r;
            if (expected_replies.size() == 0)
            begin
                $error("reply with no request outstanding: %h", data);
                mismatches++;
                return;
            end
            exp_r = expected_replies.pop_front();
            if (data[6:0] !== exp_r.length)
            begin
                $error("list_length: expected %0d, got %0d", exp_r.length, data[6:0]);
                mismatches++;
            end
            if (data[13:7] !== exp_r.cursor)
            begin
                $error("cursor_position: expected %0d, got %0d", exp_r.cursor, data[13:7]);
                mismatches++;
            end
            if (data[45:14] !== exp_r.value)
            begin
                $error("cursor_value: expected %0d, got %0d",
                       $signed(exp_r.value), $signed(data[45:14]));
                mismatches++;
            end
            if (data[46] !== exp_r.valid)
            begin
                $error("value_valid: expected %0d, got %0d", exp_r.valid, data[46]);
                mismatches++;
            end
            if (data[48:47] !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, data[48:47]);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic [IN_W-1:0]      s_tdata  = '0;
    logic [IN_USER_W-1:0] s_tuser  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    // no random idling on either side while set
    bit steady_run = 1'b0;

    list_scoreboard sb = new();

    always #5 clk = ~clk;

    positional_list_with_cursor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // accepted requests feed the shadow list
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.apply_action(act_t'(s_tuser), s_tdata[31:0], s_tdata[37:32]);
    end

    // accepted replies are checked in order
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_reply(m_tdata);
    end

    // Receiver: random stalls, plus a long hold now and then so the block backs up
    initial
    begin
        int hold_left;
        int cycle_no;
        hold_left = 0;
        cycle_no  = 0;
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (hold_left == 0 && cycle_no % HOLD_PERIOD == 0)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (!steady_run && $urandom_range(99) < 25)
                m_tready <= 1'b0;
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one request, with an occasional idle gap first, and wait for its acceptance
    task automatic send_request(act_t act, logic [31:0] value, logic [POS_W-1:0] target);
        if (!steady_run && $urandom_range(99) < 25)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tdata  <= {{(IN_W-POS_W-32){1'b0}}, target, value};
        s_tuser  <= act;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stimulus and end of run
    initial
    begin
        act_t        act;
        int          pick;
        int          len_now;
        bit          growing;
        logic [5:0]  target;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list corners, end inserts, word extremes, cursor at length
        send_request(ACT_QUERY,    32'h0,          6'd0);
        send_request(ACT_REMOVE,   32'h0,          6'd0);
        send_request(ACT_TO_END,   32'h0,          6'd0);
        send_request(ACT_BACK,     32'h0,          6'd0);
        send_request(ACT_FORWARD,  32'h0,          6'd0);
        send_request(ACT_TO_POS,   32'h0,          6'd0);
        send_request(ACT_INSERT,   32'h7FFF_FFFF,  6'd63);
        send_request(ACT_INSERT,   32'h8000_0000,  6'd0);
        send_request(ACT_TO_END,   32'h0,          6'd0);
        send_request(ACT_FORWARD,  32'h0,          6'd0);
        send_request(ACT_INSERT,   32'hFFFF_FFFF,  6'd0);
        send_request(ACT_TO_END,   32'h0,          6'd0);
        send_request(ACT_REMOVE,   32'h0,          6'd0);
        send_request(ACT_BACK,     32'h0,          6'd0);
        send_request(ACT_TO_END,   32'h0,          6'd0);
        send_request(ACT_FORWARD,  32'h0,          6'd0);
        send_request(ACT_REMOVE,   32'h0,          6'd0);
        send_request(ACT_INSERT,   32'h5A5A_A5A5,  6'd0);
        send_request(ACT_TO_POS,   32'h0,          6'd63);
        send_request(ACT_TO_POS,   32'h0,          6'd1);
        send_request(ACT_TO_START, 32'h0,          6'd0);
        send_request(ACT_REMOVE,   32'h0,          6'd0);
        send_request(ACT_REMOVE,   32'h0,          6'd0);
        send_request(ACT_QUERY,    32'h0,          6'd0);

        // random: alternate growing and shrinking phases so the list fills and empties
        growing = 1'b1;
        for (int n = 0; n < RAND_REQUESTS; n++)
        begin
            if (n % PHASE_LEN == 0 && n > 0)
                growing = !growing;
            steady_run = (n >= 600 && n < 900);
            pick    = $urandom_range(99);
            len_now = sb.shadow_len;
            if (pick < 55)
                act = growing ? ACT_INSERT : ACT_REMOVE;
            else if (pick < 60)
                act = growing ? ACT_REMOVE : ACT_INSERT;
            else
                act = act_t'($urandom_range(7));
            if ($urandom_range(99) < 75 && len_now > 0)
                target = 6'($urandom_range(len_now - 1 > 63 ? 63 : len_now - 1));
            else
                target = 6'($urandom_range(63));
            send_request(act, $urandom, target);
        end
        s_tvalid <= 1'b0;
        steady_run = 1'b0;

        while (sb.expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_replies.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
